>>> src/rte_pkg.sv
// ============================================================================
// rte_pkg
// Shared types and constants for the timestamp text to epoch converter.
// ============================================================================
package rte_pkg;

    // default depth of the record queue between parser and arithmetic
    localparam int RTE_FIFO_DEPTH = 4;

    // characters of interest
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_COLON = ":";
    localparam logic [7:0] CH_0     = "0";
    localparam logic [7:0] CH_9     = "9";
    localparam logic [7:0] CH_T     = "T";
    localparam logic [7:0] CH_UZ    = "Z";
    localparam logic [7:0] CH_LZ    = "z";

    // field index within YYYY-MM-DDTHH:MM:SS
    localparam logic [2:0] FLD_YEAR   = 3'd0;
    localparam logic [2:0] FLD_MONTH  = 3'd1;
    localparam logic [2:0] FLD_DAY    = 3'd2;
    localparam logic [2:0] FLD_HOUR   = 3'd3;
    localparam logic [2:0] FLD_MINUTE = 3'd4;
    localparam logic [2:0] FLD_SECOND = 3'd5;

    // field widths in characters, sign included
    localparam logic [2:0] YEAR_WIDTH  = 3'd4;
    localparam logic [2:0] SHORT_WIDTH = 3'd2;

    // civil-to-days constants
    localparam int DAYS_PER_ERA     = 146097;
    localparam int EPOCH_SHIFT_DAYS = 719468;
    localparam int SEC_PER_DAY      = 86400;
    localparam int SEC_PER_HOUR     = 3600;
    localparam int SEC_PER_MIN      = 60;

    // result of feeding one character to a numeric field scanner
    typedef enum logic [1:0] {
        NS_MORE,
        NS_FULL,
        NS_BACK,
        NS_FAIL
    } ns_res_t;

    // main field/separator sequence
    typedef enum logic [3:0] {
        PH_YEAR,
        PH_SEP_YM,
        PH_MONTH,
        PH_SEP_MD,
        PH_DAY,
        PH_SEP_DT,
        PH_HOUR,
        PH_SEP_HM,
        PH_MINUTE,
        PH_SEP_MS,
        PH_SECOND,
        PH_DONE,
        PH_FAIL
    } phase_t;

    // zone offset scanner sequence
    typedef enum logic [2:0] {
        ZP_FIRST,
        ZP_COLON,
        ZP_SECOND,
        ZP_OK,
        ZP_FAIL
    } zphase_t;

    // zone designator
    typedef enum logic [1:0] {
        ZONE_NONE,
        ZONE_UTC,
        ZONE_PLUS,
        ZONE_MINUS
    } zone_t;

    // numeric field scanner
    typedef struct packed {
        logic [2:0]  cnt;
        logic        sgn;
        logic        neg;
        logic [13:0] mag;
    } numscan_t;

    typedef struct packed {
        ns_res_t  res;
        numscan_t ns;
    } feed_t;

    // zone offset scanner
    typedef struct packed {
        zphase_t            ph;
        numscan_t           ns;
        logic signed [7:0]  first;
        logic signed [7:0]  second;
    } zscan_t;

    // whole parser state of one timestamp
    typedef struct packed {
        phase_t             ph;
        numscan_t           fld;
        logic signed [14:0] year;
        logic signed [7:0]  month;
        logic signed [7:0]  day;
        logic signed [7:0]  hour;
        logic signed [7:0]  minute;
        logic signed [7:0]  second;
        logic               seen_t;
        zone_t              zone;
        zscan_t             zcol;
        zscan_t             zpl;
    } parse_t;

    // parsed timestamp handed from parser to arithmetic
    typedef struct packed {
        logic               ok;
        logic signed [14:0] year;
        logic signed [7:0]  month;
        logic signed [7:0]  day;
        logic signed [7:0]  hour;
        logic signed [7:0]  minute;
        logic signed [7:0]  second;
        logic signed [7:0]  off_h;
        logic signed [7:0]  off_m;
    } rec_t;

endpackage

>>> src/rte_front.sv
// ============================================================================
// rte_front
// Character parser: scans the date, time and zone fields one character per
// word and emits one parsed record when the text ends.
// ============================================================================
module rte_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] ch
    input  logic              s_tlast,
    input  logic              full,
    output logic              push,
    output rte_pkg::rec_t     rec
);
    import rte_pkg::*;

    parse_t st_reg;
    parse_t st_next;
    logic   ended_reg;
    logic   ended_next;
    parse_t taken;
    parse_t end_src;
    logic   accept;
    logic   text_end;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic has_digits(input numscan_t s);
        return s.cnt > {2'd0, s.sgn};
    endfunction

    function automatic logic signed [14:0] ns_value(input numscan_t s);
        logic signed [14:0] m;
        m = $signed({1'b0, s.mag});
        return s.neg ? -m : m;
    endfunction

    // one character into a numeric field scanner
    function automatic feed_t num_feed(input numscan_t s, input logic [7:0] c,
                                       input logic [2:0] width);
        feed_t r;
        logic  dig;
        logic  accum;
        dig   = (c >= CH_0) && (c <= CH_9);
        r.res = NS_MORE;
        r.ns  = s;
        accum = 1'b0;
        if (s.cnt == 3'd0)
        begin
            if (is_ws(c))
            begin
                r.res = NS_MORE;
            end
            else if ((c == CH_PLUS) || (c == CH_MINUS))
            begin
                r.ns.sgn = 1'b1;
                r.ns.neg = (c == CH_MINUS);
                r.ns.cnt = 3'd1;
            end
            else if (!dig)
            begin
                r.res = NS_FAIL;
            end
            else
            begin
                accum = 1'b1;
            end
        end
        else if (!dig)
        begin
            r.res = has_digits(s) ? NS_BACK : NS_FAIL;
        end
        else
        begin
            accum = 1'b1;
        end
        if (accum)
        begin
            r.ns.mag = 14'(s.mag * 10 + {6'd0, c - CH_0});
            r.ns.cnt = s.cnt + 3'd1;
            r.res    = (r.ns.cnt >= width) ? NS_FULL : NS_MORE;
        end
        return r;
    endfunction

    // one character into a zone offset scanner, colon or plain form
    function automatic zscan_t zone_feed(input zscan_t z, input logic [7:0] c,
                                         input logic colon);
        zscan_t             q;
        feed_t              f;
        feed_t              g;
        logic signed [14:0] v;
        q = z;
        f = num_feed(z.ns, c, SHORT_WIDTH);
        g = num_feed('0, c, SHORT_WIDTH);
        v = ns_value(f.ns);
        unique case (z.ph)
            ZP_FIRST:
            begin
                if (f.res == NS_MORE)
                begin
                    q.ns = f.ns;
                end
                else if (f.res == NS_FAIL)
                begin
                    q.ph = ZP_FAIL;
                end
                else
                begin
                    q.first = v[7:0];
                    q.ns    = '0;
                    if (f.res == NS_FULL)
                    begin
                        q.ph = colon ? ZP_COLON : ZP_SECOND;
                    end
                    else if (colon)
                    begin
                        q.ph = (c == CH_COLON) ? ZP_SECOND : ZP_FAIL;
                    end
                    else
                    begin
                        // the ending character starts the minutes field
                        q.ph = (g.res == NS_FAIL) ? ZP_FAIL : ZP_SECOND;
                        q.ns = g.ns;
                    end
                end
            end
            ZP_COLON:
            begin
                q.ph = (c == CH_COLON) ? ZP_SECOND : ZP_FAIL;
            end
            ZP_SECOND:
            begin
                if (f.res == NS_MORE)
                begin
                    q.ns = f.ns;
                end
                else if (f.res == NS_FAIL)
                begin
                    q.ph = ZP_FAIL;
                end
                else
                begin
                    q.second = v[7:0];
                    q.ns     = '0;
                    q.ph     = ZP_OK;
                end
            end
            default:
            begin
                q = z;
            end
        endcase
        return q;
    endfunction

    // close a zone scanner at end of text
    function automatic zscan_t zone_end(input zscan_t z);
        zscan_t             q;
        logic signed [14:0] v;
        q = z;
        v = ns_value(z.ns);
        if ((z.ph == ZP_SECOND) && has_digits(z.ns))
        begin
            q.second = v[7:0];
            q.ph     = ZP_OK;
        end
        return q;
    endfunction

    function automatic logic [7:0] sep_char(input logic [2:0] k);
        logic [7:0] s;
        unique case (k)
            FLD_YEAR, FLD_MONTH: s = CH_MINUS;
            FLD_DAY:             s = CH_T;
            default:             s = CH_COLON;
        endcase
        return s;
    endfunction

    // store a finished field and move to the following phase
    function automatic parse_t complete_field(input parse_t p, input logic signed [14:0] v);
        parse_t     q;
        logic [2:0] k;
        q = p;
        k = p.ph[3:1];
        unique case (k)
            FLD_YEAR:   q.year   = v;
            FLD_MONTH:  q.month  = v[7:0];
            FLD_DAY:    q.day    = v[7:0];
            FLD_HOUR:   q.hour   = v[7:0];
            FLD_MINUTE: q.minute = v[7:0];
            default:    q.second = v[7:0];
        endcase
        q.fld = '0;
        q.ph  = (k >= FLD_SECOND) ? PH_DONE : phase_t'(p.ph + 4'd1);
        return q;
    endfunction

    // one character into the date/time field sequence
    function automatic parse_t main_feed(input parse_t p, input logic [7:0] c);
        parse_t     q;
        feed_t      f;
        logic [2:0] k;
        logic [2:0] width;
        q     = p;
        k     = p.ph[3:1];
        width = (p.ph == PH_YEAR) ? YEAR_WIDTH : SHORT_WIDTH;
        f     = num_feed(p.fld, c, width);
        if (p.ph < PH_DONE)
        begin
            if (!p.ph[0])
            begin
                unique case (f.res)
                    NS_MORE: q.fld = f.ns;
                    NS_FAIL: q.ph  = PH_FAIL;
                    default:
                    begin
                        q = complete_field(p, ns_value(f.ns));
                        // a non-digit that closed the field is the separator
                        if ((f.res == NS_BACK) && (k < FLD_SECOND))
                        begin
                            q.ph = (c == sep_char(k)) ? phase_t'(q.ph + 4'd1) : PH_FAIL;
                        end
                    end
                endcase
            end
            else
            begin
                q.ph = (c == sep_char(k)) ? phase_t'(p.ph + 4'd1) : PH_FAIL;
            end
        end
        return q;
    endfunction

    // zone search, zone scanners and field sequence for one character
    function automatic parse_t take_char(input parse_t p, input logic [7:0] c);
        parse_t q;
        q = p;
        if ((p.zone == ZONE_NONE) && p.seen_t)
        begin
            if ((c == CH_UZ) || (c == CH_LZ))
            begin
                q.zone = ZONE_UTC;
            end
            else if (c == CH_PLUS)
            begin
                q.zone = ZONE_PLUS;
            end
            else if (c == CH_MINUS)
            begin
                q.zone = ZONE_MINUS;
            end
        end
        else if ((p.zone == ZONE_PLUS) || (p.zone == ZONE_MINUS))
        begin
            q.zcol = zone_feed(p.zcol, c, 1'b1);
            q.zpl  = zone_feed(p.zpl, c, 1'b0);
        end
        if (c == CH_T)
        begin
            q.seen_t = 1'b1;
        end
        q = main_feed(q, c);
        return q;
    endfunction

    // close the text: last field, zone offset, record
    function automatic rec_t finish(input parse_t p);
        parse_t q;
        zscan_t zc;
        zscan_t zp;
        rec_t   r;
        q  = p;
        zc = zone_end(p.zcol);
        zp = zone_end(p.zpl);
        if ((p.ph < PH_DONE) && !p.ph[0])
        begin
            if (has_digits(p.fld))
            begin
                q = complete_field(p, ns_value(p.fld));
            end
            else
            begin
                q.ph = PH_FAIL;
            end
        end
        r.ok     = (q.ph == PH_DONE);
        r.year   = q.year;
        r.month  = q.month;
        r.day    = q.day;
        r.hour   = q.hour;
        r.minute = q.minute;
        r.second = q.second;
        r.off_h  = '0;
        r.off_m  = '0;
        if ((p.zone == ZONE_PLUS) || (p.zone == ZONE_MINUS))
        begin
            if (zc.ph == ZP_OK)
            begin
                r.off_h = zc.first;
                r.off_m = zc.second;
            end
            else if (zp.ph == ZP_OK)
            begin
                r.off_h = zp.first;
                r.off_m = zp.second;
            end
            if (p.zone == ZONE_MINUS)
            begin
                r.off_h = -r.off_h;
                r.off_m = -r.off_m;
            end
        end
        return r;
    endfunction

    // classify the word and compute the next parser state
    always_comb
    begin
        s_tready   = !full;
        accept     = s_tvalid && s_tready;
        text_end   = (s_tdata == CH_NUL) || s_tlast;
        taken      = take_char(st_reg, s_tdata);
        end_src    = (s_tdata == CH_NUL) ? st_reg : taken;
        rec        = finish(end_src);
        push       = accept && !ended_reg && text_end;
        st_next    = st_reg;
        ended_next = ended_reg;
        if (accept)
        begin
            if (ended_reg)
            begin
                // words after an unmarked end are dropped until the marked one
                if (s_tlast)
                begin
                    st_next    = '0;
                    ended_next = 1'b0;
                end
            end
            else if (text_end)
            begin
                st_next    = '0;
                ended_next = !s_tlast;
            end
            else
            begin
                st_next = taken;
            end
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= '0;
            ended_reg <= 1'b0;
        end
        else
        begin
            st_reg    <= st_next;
            ended_reg <= ended_next;
        end
    end

    // a marked last word leaves the parser ready for a fresh timestamp
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast) |=> ((st_reg.ph == PH_YEAR) && !ended_reg))
        else $error("parser not cleared after last word");

endmodule

>>> src/rte_fifo.sv
// ============================================================================
// rte_fifo
// Short record queue between the parser and the epoch arithmetic.
// ============================================================================
module rte_fifo #(
    parameter int DEPTH = rte_pkg::RTE_FIFO_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  rte_pkg::rec_t     wr_data,
    output logic              full,
    input  logic              rd_en,
    output rte_pkg::rec_t     rd_data,
    output logic              empty
);
    import rte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rec_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // status and pointer updates
    always_comb
    begin
        full        = (cnt_reg == CNT_W'(DEPTH));
        empty       = (cnt_reg == '0);
        rd_data     = mem[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> !full)
        else $error("record queue overflow");

    assert property (@(posedge clk) disable iff (!rst_n) rd_en |-> !empty)
        else $error("record queue underflow");

endmodule

>>> src/rte_back.sv
// ============================================================================
// rte_back
// Epoch arithmetic: civil-to-days conversion, time of day and zone offset,
// saturation, in a stall-together pipeline ending in the output register.
// ============================================================================
module rte_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  rte_pkg::rec_t     in_data,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // [39:0] epoch_seconds
    output logic              m_tuser    // [0] valid_res
);
    import rte_pkg::*;

    localparam logic signed [49:0] EPOCH_HI = 50'sd400000000000;
    localparam logic signed [49:0] EPOCH_LO = -EPOCH_HI;
    // offsets that keep the small floor divisions non-negative
    localparam int YEAR_BIAS  = 10400;
    localparam int ERA_BIAS   = YEAR_BIAS / 400;
    localparam int DOY_BIAS   = 15610;
    localparam int DOY_QBIAS  = DOY_BIAS / 5;
    // floor(2^32 / 5), used when the shifted month wraps below zero
    localparam logic [31:0] WRAP_DIV5 = 32'd858993459;

    typedef struct packed {
        logic               ok;
        logic               mneg;
        logic [14:0]        u;
        logic [14:0]        w;
        logic signed [7:0]  day;
        logic signed [20:0] tsec;
    } stage_a_t;

    typedef struct packed {
        logic               ok;
        logic               mneg;
        logic [14:0]        u;
        logic [5:0]         q;
        logic [12:0]        qd;
        logic signed [7:0]  day;
        logic signed [20:0] tsec;
    } stage_b_t;

    typedef struct packed {
        logic               ok;
        logic [8:0]         yoe;
        logic signed [6:0]  era;
        logic [31:0]        doy;
        logic signed [20:0] tsec;
    } stage_c_t;

    typedef struct packed {
        logic               ok;
        logic [31:0]        doe;
        logic [31:0]        eterm;
        logic signed [20:0] tsec;
    } stage_d_t;

    typedef struct packed {
        logic               ok;
        logic signed [31:0] days;
        logic signed [20:0] tsec;
    } stage_e_t;

    typedef struct packed {
        logic               ok;
        logic signed [48:0] prod;
        logic signed [20:0] tsec;
    } stage_f_t;

    stage_a_t    a_reg, a_next;
    stage_b_t    b_reg, b_next;
    stage_c_t    c_reg, c_next;
    stage_d_t    d_reg, d_next;
    stage_e_t    e_reg, e_next;
    stage_f_t    f_reg, f_next;
    logic [5:0]  vld_reg, vld_next;
    logic        out_vld_reg, out_vld_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        out_ok_reg, out_ok_next;
    logic        advance;

    logic               le2;
    logic signed [15:0] y16;
    logic signed [8:0]  mp;
    logic signed [15:0] s16;
    logic signed [8:0]  dh;
    logic signed [8:0]  dm;
    logic [20:0]        pq;
    logic [30:0]        pd;
    logic signed [13:0] qs;
    logic [1:0]         c100;
    logic signed [49:0] sum;
    logic signed [49:0] sat;

    // the whole pipeline moves when the output word is free or taken
    always_comb
    begin
        advance  = !out_vld_reg || m_tready;
        pop      = advance && in_valid;
        vld_next = {vld_reg[4:0], in_valid};
        out_vld_next = vld_reg[5];
    end

    // stage a: year shift, shifted month, time of day less zone offset
    always_comb
    begin
        le2         = !in_data.month[7] && (in_data.month[6:0] <= 7'd2);
        y16         = {in_data.year[14], in_data.year} - (le2 ? 16'sd1 : 16'sd0);
        mp          = le2 ? ({in_data.month[7], in_data.month} + 9'sd9)
                          : ({in_data.month[7], in_data.month} - 9'sd3);
        s16         = 16'(mp * 16'sd153) + 16'sd2;
        dh          = {in_data.hour[7], in_data.hour} - {in_data.off_h[7], in_data.off_h};
        dm          = {in_data.minute[7], in_data.minute} - {in_data.off_m[7], in_data.off_m};
        a_next.ok   = in_data.ok;
        a_next.mneg = in_data.month[7];
        a_next.u    = 15'(y16 + 16'(YEAR_BIAS));
        a_next.w    = 15'(s16 + 16'(DOY_BIAS) + {15'd0, in_data.month[7]});
        a_next.day  = in_data.day;
        a_next.tsec = 21'(dh * 21'(SEC_PER_HOUR)) + 21'(dm * 21'(SEC_PER_MIN))
                    + {{13{in_data.second[7]}}, in_data.second};
    end

    // stage b: divisions by 400 and 5 through reciprocal multiplies
    always_comb
    begin
        pq          = {10'd0, a_reg.u[14:4]} * 21'd1311;
        pd          = {16'd0, a_reg.w} * 31'd52429;
        b_next.ok   = a_reg.ok;
        b_next.mneg = a_reg.mneg;
        b_next.u    = a_reg.u;
        b_next.q    = pq[20:15];
        b_next.qd   = pd[30:18];
        b_next.day  = a_reg.day;
        b_next.tsec = a_reg.tsec;
    end

    // stage c: year of era, era, day of year
    always_comb
    begin
        qs          = $signed({1'b0, b_reg.qd}) - 14'(DOY_QBIAS);
        c_next.ok   = b_reg.ok;
        c_next.yoe  = 9'(b_reg.u - 15'(b_reg.q * 15'd400));
        c_next.era  = $signed({1'b0, b_reg.q}) - 7'(ERA_BIAS);
        c_next.doy  = {{18{qs[13]}}, qs} + (b_reg.mneg ? WRAP_DIV5 : 32'd0)
                    + {{24{b_reg.day[7]}}, b_reg.day} - 32'd1;
        c_next.tsec = b_reg.tsec;
    end

    // stage d: day of era and era base
    always_comb
    begin
        if (c_reg.yoe >= 9'd300)
        begin
            c100 = 2'd3;
        end
        else if (c_reg.yoe >= 9'd200)
        begin
            c100 = 2'd2;
        end
        else if (c_reg.yoe >= 9'd100)
        begin
            c100 = 2'd1;
        end
        else
        begin
            c100 = 2'd0;
        end
        d_next.ok    = c_reg.ok;
        d_next.doe   = 32'(c_reg.yoe) * 32'd365 + 32'(c_reg.yoe[8:2]) - 32'(c100) + c_reg.doy;
        d_next.eterm = 32'(c_reg.era * 32'sd146097);
        d_next.tsec  = c_reg.tsec;
    end

    // stage e: days since the epoch, wrapping at 32 bits
    always_comb
    begin
        e_next.ok   = d_reg.ok;
        e_next.days = $signed(d_reg.eterm + d_reg.doe - 32'(EPOCH_SHIFT_DAYS));
        e_next.tsec = d_reg.tsec;
    end

    // stage f: days to seconds
    always_comb
    begin
        f_next.ok   = e_reg.ok;
        f_next.prod = e_reg.days * 49'sd86400;
        f_next.tsec = e_reg.tsec;
    end

    // output: add time of day, saturate, zero when not valid
    always_comb
    begin
        sum = {f_reg.prod[48], f_reg.prod} + {{29{f_reg.tsec[20]}}, f_reg.tsec};
        if (sum > EPOCH_HI)
        begin
            sat = EPOCH_HI;
        end
        else if (sum < EPOCH_LO)
        begin
            sat = EPOCH_LO;
        end
        else
        begin
            sat = sum;
        end
        out_ok_next   = f_reg.ok;
        out_data_next = f_reg.ok ? sat[39:0] : 40'd0;
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            a_reg        <= a_next;
            b_reg        <= b_next;
            c_reg        <= c_next;
            d_reg        <= d_next;
            e_reg        <= e_next;
            f_reg        <= f_next;
            out_data_reg <= out_data_next;
            out_ok_reg   <= out_ok_next;
        end
    end

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld_reg     <= vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == 40'd0))
        else $error("invalid result carries nonzero seconds");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
        (($signed(m_tdata) <= 40'sd400000000000) && ($signed(m_tdata) >= -40'sd400000000000)))
        else $error("epoch seconds outside saturation range");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");

endmodule

>>> src/rfc3339_timestamp_to_epoch_top.sv
// ============================================================================
// rfc3339_timestamp_to_epoch_top
// Timestamp text to UTC epoch seconds: character parser, record queue and
// epoch arithmetic pipeline.
// ============================================================================
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tdata[7:0] ch, tlast last
//  m_*       out  m_tvalid/m_tready    tdata[39:0] epoch_seconds, tuser valid_res
//
//  one character word per cycle while s_tready is high; the parser decides each word in its cycle
//  a result passes through the record queue, stages a to f and the output register
//  the queue holds FIFO_DEPTH records; s_tready drops only while it is full
//  the arithmetic pipeline halts as a whole while the output word is held
//  reset clears parser state, queue pointers and stage valid bits at once
module rfc3339_timestamp_to_epoch_top #(
    parameter int FIFO_DEPTH = rte_pkg::RTE_FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [39:0] epoch_seconds
    output logic        m_tuser    // [0] valid_res
);
    import rte_pkg::*;

    logic push;
    logic full;
    logic empty;
    logic pop;
    rec_t wr_rec;
    rec_t rd_rec;

    // character parser
    rte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .full     (full),
        .push     (push),
        .rec      (wr_rec)
    );

    // record queue
    rte_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (wr_rec),
        .full    (full),
        .rd_en   (pop),
        .rd_data (rd_rec),
        .empty   (empty)
    );

    // epoch arithmetic
    rte_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (!empty),
        .in_data  (rd_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> bench/rte_epoch_checker.sv
// ============================================================================
// rte_epoch_checker
// Watches both streams of the timestamp converter, parses every accepted
// character word with its own copy of the scanner, predicts the epoch result
// of each finished text and compares it with the result words in order.
// ============================================================================
module rte_epoch_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [39:0] epoch_seconds
    input  logic        m_tuser,   // [0] valid_res
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rte_pkg::*;

    localparam longint EPOCH_LIMIT = 64'sd400000000000;

    // one numeric field: characters taken, sign, magnitude
    typedef struct {
        int cnt;
        bit sgn;
        bit neg;
        int mag;
    } field_scan_t;

    // one reading of the zone offset
    typedef struct {
        zphase_t     ph;
        field_scan_t fs;
        int          first;
        int          second;
    } offset_scan_t;

    typedef struct {
        logic [39:0] secs;
        logic        ok;
    } epoch_word_t;

    // parser state of the text in progress
    phase_t       ph;
    field_scan_t  fld;
    int           yr, mon, dy, hr, mi, sc;
    bit           fields_done;
    bit           seen_t;
    bit           text_over;
    zone_t        zone;
    offset_scan_t off_colon;
    offset_scan_t off_plain;

    epoch_word_t  expected_epochs[$];

    function automatic field_scan_t blank_field();
        field_scan_t f;
        f.cnt = 0;
        f.sgn = 1'b0;
        f.neg = 1'b0;
        f.mag = 0;
        return f;
    endfunction

    function automatic offset_scan_t blank_offset();
        offset_scan_t z;
        z.ph     = ZP_FIRST;
        z.fs     = blank_field();
        z.first  = 0;
        z.second = 0;
        return z;
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic bit has_digits(field_scan_t f);
        return f.cnt > (f.sgn ? 1 : 0);
    endfunction

    function automatic int signed_value(field_scan_t f);
        return f.neg ? -f.mag : f.mag;
    endfunction

    // scanf-style field: blanks, optional sign counted in the width, digits
    function automatic ns_res_t scan_char(inout field_scan_t f, input logic [7:0] c,
                                          input int width);
        bit digit;
        digit = (c >= CH_0 && c <= CH_9);
        if (f.cnt == 0)
        begin
            if (is_space(c))
                return NS_MORE;
            if (c == CH_PLUS || c == CH_MINUS)
            begin
                f.sgn = 1'b1;
                f.neg = (c == CH_MINUS);
                f.cnt = 1;
                return NS_MORE;
            end
            if (!digit)
                return NS_FAIL;
        end
        else if (!digit)
            return has_digits(f) ? NS_BACK : NS_FAIL;
        f.mag = f.mag * 10 + (int'(c) - int'(CH_0));
        f.cnt++;
        return (f.cnt >= width) ? NS_FULL : NS_MORE;
    endfunction

    // offset as HH:MM (colon set) or HHMM
    function automatic void offset_char(inout offset_scan_t z, input logic [7:0] c,
                                        input bit colon);
        ns_res_t r;
        bit      again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            if (z.ph == ZP_FIRST || z.ph == ZP_SECOND)
            begin
                r = scan_char(z.fs, c, 2);
                if (r == NS_FAIL)
                    z.ph = ZP_FAIL;
                else if (r != NS_MORE)
                begin
                    if (z.ph == ZP_FIRST)
                    begin
                        z.first = signed_value(z.fs);
                        z.ph    = colon ? ZP_COLON : ZP_SECOND;
                    end
                    else
                    begin
                        z.second = signed_value(z.fs);
                        z.ph     = ZP_OK;
                    end
                    z.fs  = blank_field();
                    // the ending character goes on to the next step
                    again = (r == NS_BACK && z.ph != ZP_OK);
                end
            end
            else if (z.ph == ZP_COLON)
                z.ph = (c == CH_COLON) ? ZP_SECOND : ZP_FAIL;
        end
    endfunction

    function automatic bit offset_end(inout offset_scan_t z);
        if (z.ph == ZP_SECOND && has_digits(z.fs))
        begin
            z.second = signed_value(z.fs);
            z.ph     = ZP_OK;
        end
        return z.ph == ZP_OK;
    endfunction

    function automatic logic [7:0] separator_after(phase_t p);
        case (p)
            PH_SEP_DT: return CH_T;
            PH_SEP_HM, PH_SEP_MS: return CH_COLON;
            default: return CH_MINUS;
        endcase
    endfunction

    function automatic void complete_field();
        int v;
        v = signed_value(fld);
        case (ph)
            PH_YEAR:   yr  = v;
            PH_MONTH:  mon = v;
            PH_DAY:    dy  = v;
            PH_HOUR:   hr  = v;
            PH_MINUTE: mi  = v;
            default:   sc  = v;
        endcase
        fld = blank_field();
        if (ph == PH_SECOND)
        begin
            ph          = PH_DONE;
            fields_done = 1'b1;
        end
        else
            ph = phase_t'(ph + 1);
    endfunction

    // date and time fields with their separators
    function automatic void field_char(logic [7:0] c);
        ns_res_t r;
        int      width;
        bit      again;
        again = 1'b1;
        while (again && ph < PH_DONE)
        begin
            again = 1'b0;
            if (!ph[0])
            begin
                width = (ph == PH_YEAR) ? int'(YEAR_WIDTH) : int'(SHORT_WIDTH);
                r = scan_char(fld, c, width);
                if (r == NS_FAIL)
                    ph = PH_FAIL;
                else if (r != NS_MORE)
                begin
                    complete_field();
                    again = (r == NS_BACK);
                end
            end
            else
                ph = (c == separator_after(ph)) ? phase_t'(ph + 1) : PH_FAIL;
        end
    endfunction

    // zone search starts after the first T; a sign is also seen by the fields
    function automatic void take_char(logic [7:0] c);
        if (zone == ZONE_NONE && seen_t)
        begin
            if (c == CH_UZ || c == CH_LZ)
                zone = ZONE_UTC;
            else if (c == CH_PLUS)
                zone = ZONE_PLUS;
            else if (c == CH_MINUS)
                zone = ZONE_MINUS;
            if (zone == ZONE_PLUS || zone == ZONE_MINUS)
            begin
                field_char(c);
                return;
            end
        end
        else if (zone == ZONE_PLUS || zone == ZONE_MINUS)
        begin
            offset_char(off_colon, c, 1'b1);
            offset_char(off_plain, c, 1'b0);
        end
        if (c == CH_T)
            seen_t = 1'b1;
        field_char(c);
    endfunction

    // civil-to-days with 32-bit wrap, then seconds with saturation
    function automatic logic [39:0] epoch_of_fields();
        bit [31:0] mu, du, yoe, t, doy, doe, dw;
        int        y, era;
        longint    days, tod, off, e;
        mu   = mon;
        du   = dy;
        y    = yr - ((mu <= 2) ? 1 : 0);
        era  = (y >= 0 ? y : y - 399) / 400;
        yoe  = y - era * 400;
        t    = (mu > 2) ? mu - 3 : mu + 9;
        t    = 153 * t + 2;
        doy  = t / 5 + du - 1;
        doe  = yoe * 365 + yoe / 4 - yoe / 100 + yoe / 400 + doy;
        dw   = era * DAYS_PER_ERA + doe - EPOCH_SHIFT_DAYS;
        days = longint'(signed'(dw));
        tod  = longint'(hr) * SEC_PER_HOUR + longint'(mi) * SEC_PER_MIN + sc;
        off  = 0;
        if (zone == ZONE_PLUS || zone == ZONE_MINUS)
        begin
            if (offset_end(off_colon))
                off = longint'(off_colon.first) * SEC_PER_HOUR
                    + longint'(off_colon.second) * SEC_PER_MIN;
            else if (offset_end(off_plain))
                off = longint'(off_plain.first) * SEC_PER_HOUR
                    + longint'(off_plain.second) * SEC_PER_MIN;
            if (zone == ZONE_MINUS)
                off = -off;
        end
        e = days * SEC_PER_DAY + tod - off;
        if (e > EPOCH_LIMIT)
            e = EPOCH_LIMIT;
        if (e < -EPOCH_LIMIT)
            e = -EPOCH_LIMIT;
        return e[39:0];
    endfunction

    function automatic void finish_text();
        epoch_word_t w;
        // a field cut short by the end of text counts when it has a digit
        if (ph < PH_DONE && !ph[0])
        begin
            if (has_digits(fld))
                complete_field();
            else
                ph = PH_FAIL;
        end
        if (fields_done)
        begin
            w.secs = epoch_of_fields();
            w.ok   = 1'b1;
        end
        else
        begin
            w.secs = '0;
            w.ok   = 1'b0;
        end
        expected_epochs.insert(expected_epochs.size(), w);
    endfunction

    function automatic void clear_text();
        ph          = PH_YEAR;
        fld         = blank_field();
        yr          = 0;
        mon         = 0;
        dy          = 0;
        hr          = 0;
        mi          = 0;
        sc          = 0;
        fields_done = 1'b0;
        seen_t      = 1'b0;
        text_over   = 1'b0;
        zone        = ZONE_NONE;
        off_colon   = blank_offset();
        off_plain   = blank_offset();
    endfunction

    // a NUL ends the text; words after it are dropped up to the last mark
    function automatic void accept_char(logic [7:0] c, logic lst);
        if (text_over)
        begin
            if (lst)
                clear_text();
        end
        else if (c == CH_NUL)
        begin
            finish_text();
            if (lst)
                clear_text();
            else
                text_over = 1'b1;
        end
        else
        begin
            take_char(c);
            if (lst)
            begin
                finish_text();
                clear_text();
            end
        end
    endfunction

    function automatic void check_word();
        epoch_word_t want;
        if (expected_epochs.size() == 0)
        begin
            errors++;
            $error("result word with no text pending: epoch_seconds %0d valid_res %0b",
                   $signed(m_tdata), m_tuser);
            return;
        end
        want = expected_epochs.pop_front();
        if (m_tdata !== want.secs)
        begin
            errors++;
            $error("epoch_seconds: expected %0d, actual %0d",
                   $signed(want.secs), $signed(m_tdata));
        end
        if (m_tuser !== want.ok)
        begin
            errors++;
            $error("valid_res: expected %0b, actual %0b", want.ok, m_tuser);
        end
    endfunction

    // input word first: its result can never leave in the same cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_text();
            expected_epochs.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                accept_char(s_tdata, s_tlast);
            if (m_tvalid && m_tready)
                check_word();
            pending <= expected_epochs.size();
        end
    end

endmodule

>>> bench/rfc3339_timestamp_to_epoch_top_test.sv
// ============================================================================
// rfc3339_timestamp_to_epoch_top_test
// Feeds timestamp texts one character word at a time: directed corner cases,
// a back-pressure burst, then random well-formed, broken and noise texts with
// random idling on both streams. The checker predicts and compares results.
// ============================================================================
module rfc3339_timestamp_to_epoch_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rte_pkg::*;

    localparam int RANDOM_WORDS = 210;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 16;
    localparam string PUNCT     = "-:TZz+ .t";

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tuser;
    int          errors;
    int          pending;

    bit          steady = 1'b0;
    int          hold_req = 0;
    int          hold_taken = 0;
    int          words_sent = 0;
    logic [7:0]  text[$];

    rfc3339_timestamp_to_epoch_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    rte_epoch_checker epoch_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #1ms;
        $display("rfc3339_timestamp_to_epoch_top: mismatch");
        $finish;
    end

    // result side: random stalls, or one long hold-off on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_taken != hold_req)
            begin
                hold_taken++;
                m_tready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 36);
        end
    end

    // append one character to the text being built
    function automatic void put_char(input logic [7:0] c);
        text.insert(text.size(), c);
    endfunction

    // one character word, with random gaps before it
    task automatic send_word(input logic [7:0] c, input bit lst);
        while (!steady && $urandom_range(99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        words_sent++;
    endtask

    // the final word of the text carries the last mark
    task automatic send_text();
        for (int i = 0; i < text.size(); i++)
            send_word(text[i], i == text.size() - 1);
    endtask

    task automatic load_string(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic send_string(input string s);
        load_string(s);
        send_text();
    endtask

    // sender pauses until every result is out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // numeric field, mostly full width, sometimes blanks, a sign or fewer digits
    task automatic put_field(input int width);
        int n;
        if ($urandom_range(9) == 0)
            put_char($urandom_range(1) ? CH_SPACE : 8'($urandom_range(9, 13)));
        n = width;
        if ($urandom_range(9) == 0)
        begin
            put_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
            n--;
        end
        if ($urandom_range(5) == 0)
            n = $urandom_range(1, n);
        repeat (n) put_char(8'(CH_0 + $urandom_range(9)));
    endtask

    task automatic make_timestamp();
        text.delete();
        put_field(YEAR_WIDTH);
        put_char(CH_MINUS);
        put_field(SHORT_WIDTH);
        put_char(CH_MINUS);
        put_field(SHORT_WIDTH);
        put_char(CH_T);
        put_field(SHORT_WIDTH);
        put_char(CH_COLON);
        put_field(SHORT_WIDTH);
        put_char(CH_COLON);
        put_field(SHORT_WIDTH);
        // fractional seconds
        if ($urandom_range(4) == 0)
        begin
            put_char(".");
            repeat ($urandom_range(1, 3)) put_char(8'(CH_0 + $urandom_range(9)));
        end
        // zone designator
        case ($urandom_range(7))
            1: put_char(CH_UZ);
            2: put_char(CH_LZ);
            3, 4:
            begin
                put_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
                put_field(SHORT_WIDTH);
                put_char(CH_COLON);
                put_field(SHORT_WIDTH);
            end
            5:
            begin
                put_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
                put_field(SHORT_WIDTH);
                put_field(SHORT_WIDTH);
            end
            6:
            begin
                put_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
                repeat ($urandom_range(3))
                    put_char($urandom_range(3) == 0 ? CH_COLON
                                                    : 8'(CH_0 + $urandom_range(9)));
            end
            default: ;
        endcase
        // trailing junk
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 3)) put_char(8'($urandom_range(1, 255)));
    endtask

    task automatic make_noise();
        text.delete();
        repeat ($urandom_range(1, 12))
        begin
            case ($urandom_range(3))
                0: put_char(8'($urandom_range(255)));
                1: put_char(8'(CH_0 + $urandom_range(9)));
                2: put_char(PUNCT[$urandom_range(PUNCT.len() - 1)]);
                default: put_char(8'($urandom_range(1, 255)));
            endcase
        end
    endtask

    // cut the text short or spoil one character
    task automatic break_text();
        int k;
        if (text.size() > 1 && $urandom_range(1))
        begin
            k = $urandom_range(1, text.size() - 1);
            while (text.size() > k)
                void'(text.pop_back());
        end
        else
            text[$urandom_range(text.size() - 1)] = 8'($urandom_range(255));
    endtask

    initial
    begin
        int start;
        int pick;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        send_string("1970-01-01T00:00:00Z");
        send_string("9999-12-31T23:59:59+14:00");
        send_string("-999-01-01T00:00:00-1230");
        send_string("2024-02-29T12:34:56+05");
        send_string(" 2000-1-2T\t3:4:5");
        send_string("+12-03-04T05:06");
        send_string("2020/01/01T00:00:00");
        send_string("2020-+x");
        send_string("9999-99-99T99:99:99z");
        send_string("2000--9--9T-9:-9:-9");
        send_string("2023-06-15T10:20:30.5+01:30");
        // text ended by a NUL that is not the last word
        load_string("2021-05-06T07:08:09");
        put_char(CH_NUL);
        put_char(CH_LZ);
        put_char(8'hff);
        put_char("!");
        send_text();
        // empty text
        text.delete();
        put_char(CH_NUL);
        send_text();
        load_string("1969-12-31T23:59:59");
        put_char(CH_NUL);
        send_text();
        drain();

        // result side holds off while one-word texts keep coming
        hold_req++;
        repeat (32) send_word(8'($urandom_range(1, 255)), 1'b1);
        drain();

        // random texts, one stretch with no idling on either side
        start = words_sent;
        while (words_sent - start < RANDOM_WORDS)
        begin
            steady = (words_sent - start >= 70 && words_sent - start < 150);
            pick = $urandom_range(99);
            if (pick < 12)
                make_noise();
            else
            begin
                make_timestamp();
                if (pick < 35)
                    break_text();
            end
            case ($urandom_range(9))
                0: put_char(CH_NUL);
                1:
                begin
                    put_char(CH_NUL);
                    repeat ($urandom_range(3)) put_char(8'($urandom_range(255)));
                    put_char(8'($urandom_range(255)));
                end
                default: ;
            endcase
            send_text();
            if ($urandom_range(19) == 0)
                drain();
        end
        steady = 1'b0;
        drain();

        if (errors == 0)
            $display("rfc3339_timestamp_to_epoch_top: match");
        else
            $display("rfc3339_timestamp_to_epoch_top: mismatch");
        $finish;
    end

endmodule
